// File: sv/fbr_pkg.sv
// fbr_pkg: shared types and constants of the frame receiver
// no dependencies; imported by every module of the block

package fbr_pkg;

  // header layout
  localparam int unsigned HdrLen   = 6;
  localparam int unsigned CsumLen  = 2;
  localparam int unsigned CmdPos   = 9;
  localparam int unsigned StatPos  = 14;

  localparam logic [7:0] HdrByte0  = 8'h1e;
  localparam logic [7:0] HdrByte1  = 8'h0c;
  localparam logic [7:0] HdrByte2  = 8'h00;

  // sequence byte rules
  localparam logic [7:0] SeqHiMask = 8'hf0;
  localparam logic [7:0] SeqHiOne  = 8'h40;
  localparam logic [7:0] OneFrame  = 8'h01;

  // sms sub-commands
  localparam logic [7:0] SubSendStatus = 8'h03;
  localparam logic [7:0] SubIncoming   = 8'h04;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgAckType    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSmsType    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdType     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgNetSttType = 2'd3;

  typedef enum logic [2:0] {
    KIND_ACK          = 3'd0,
    KIND_SMS_STATUS   = 3'd1,
    KIND_ID           = 3'd2,
    KIND_SMS_INCOMING = 3'd3,
    KIND_NET_STATUS   = 3'd4,
    KIND_UNKNOWN      = 3'd5,
    KIND_MULTI_DROP   = 3'd6
  } frame_kind_e;

  // configured type bytes
  typedef struct packed {
    logic [7:0] ack_byte;
    logic [7:0] sms_type;
    logic [7:0] id_type;
    logic [7:0] net_type;
  } cfg_t;

  // header fields of one complete frame, handed from parser to classifier
  typedef struct packed {
    logic [7:0] type_byte;
    logic [7:0] length;
    logic [7:0] seq;
    logic [7:0] frames;
    logic [7:0] command;
    logic [7:0] status;
  } frame_rec_t;

endpackage

// File: sv/fbus_frame_receiver_top.sv
// a frame's record enters the frame queue as its last byte is accepted, then moves to the classifier's output register
// throughput: one byte per cycle; stalls only when the two-entry frame queue is full
// the parser checks the header and counts offsets, the classifier matches type bytes
// reset (async, active low) clears the byte counter, captured fields and queue,
// and loads the type registers with 127, 2, 209 and 10

module fbus_frame_receiver_top import fbr_pkg::*; #(
  parameter int unsigned MaxPayload = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         frame_kind_o,
  output logic [7:0]         frame_type_byte_o,
  output logic [7:0]         payload_length_o,
  output logic [7:0]         sequence_byte_o,
  output logic               send_ack_o,
  output logic [2:0]         ack_sequence_o,
  output logic               sms_sent_ok_o
);

  cfg_t       cfg_q, cfg_d;
  frame_rec_t push_rec, head_rec;
  logic       push, full, pop, empty;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAckType:    cfg_d.ack_byte = cfg_wdata_i;
        CfgSmsType:    cfg_d.sms_type = cfg_wdata_i;
        CfgIdType:     cfg_d.id_type  = cfg_wdata_i;
        CfgNetSttType: cfg_d.net_type = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_byte <= 8'd127;
      cfg_q.sms_type <= 8'd2;
      cfg_q.id_type  <= 8'd209;
      cfg_q.net_type <= 8'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // byte parser
  fbr_front #(.MaxPayload(MaxPayload)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_rec_o    (push_rec)
  );

  // frame queue
  fbr_fifo #(.Depth(2)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_rec)
  );

  // classifier
  fbr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_empty_i         (empty),
    .q_head_i          (head_rec),
    .q_pop_o           (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_kind_o      (frame_kind_o),
    .frame_type_byte_o (frame_type_byte_o),
    .payload_length_o  (payload_length_o),
    .sequence_byte_o   (sequence_byte_o),
    .send_ack_o        (send_ack_o),
    .ack_sequence_o    (ack_sequence_o),
    .sms_sent_ok_o     (sms_sent_ok_o)
  );

endmodule

// File: sv/fbr_front.sv
// fbr_front: byte-level parser, header check, field capture, frame end detect
// depends on fbr_pkg

module fbr_front import fbr_pkg::*; #(
  parameter int unsigned MaxPayload = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output frame_rec_t q_rec_o
);

  localparam int unsigned MaxTotal = HdrLen + MaxPayload + 1 + CsumLen;
  localparam int unsigned CntW     = $clog2(MaxTotal + 1);

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc, total, seq_pos, fc_pos;
  logic [7:0] type_q, type_d, len_q, len_d, hdr4_q, hdr4_d;
  logic [7:0] cmd_q, cmd_d, stat_q, stat_d, seq_q, seq_d, fc_q, fc_d;
  logic       accept, bad, frame_end;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;

  // header sync rules
  always_comb begin
    bad = 1'b0;
    if (cnt_q == CntW'(0) && rx_byte_i != HdrByte0) bad = 1'b1;
    if (cnt_q == CntW'(1) && rx_byte_i != HdrByte1) bad = 1'b1;
    if (cnt_q == CntW'(2) && rx_byte_i != HdrByte2) bad = 1'b1;
    if (cnt_q == CntW'(HdrLen - 1) && {1'b0, rx_byte_i} > 9'(MaxPayload)) bad = 1'b1;
  end

  // frame geometry from the stored length
  assign cnt_inc = cnt_q + CntW'(1);
  assign total   = CntW'(HdrLen + CsumLen) + CntW'(len_q) + CntW'(len_q[0]);
  assign seq_pos = CntW'(HdrLen - 1) + CntW'(len_q);
  assign fc_pos  = CntW'(HdrLen - 2) + CntW'(len_q);

  // field capture
  always_comb begin
    type_d = type_q;
    len_d  = len_q;
    hdr4_d = hdr4_q;
    cmd_d  = cmd_q;
    stat_d = stat_q;
    seq_d  = seq_q;
    fc_d   = fc_q;
    if (accept && !bad) begin
      if (cnt_q == CntW'(3)) type_d = rx_byte_i;
      if (cnt_q == CntW'(4)) hdr4_d = rx_byte_i;
      if (cnt_q == CntW'(HdrLen - 1)) len_d = rx_byte_i;
      if (cnt_q == CntW'(CmdPos)) cmd_d = rx_byte_i;
      if (cnt_q == CntW'(StatPos)) stat_d = rx_byte_i;
      if (cnt_q >= CntW'(HdrLen)) begin
        if (len_q >= 8'd1 && cnt_q == seq_pos) seq_d = rx_byte_i;
        if (len_q >= 8'd2 && cnt_q == fc_pos) fc_d = rx_byte_i;
      end
    end
  end

  // byte counter and frame end
  assign frame_end = (cnt_inc >= CntW'(HdrLen)) && (cnt_inc >= total);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      priority if (bad)  cnt_d = '0;
      else if (frame_end) cnt_d = '0;
      else                cnt_d = cnt_inc;
    end
  end

  // frame record for the classifier
  assign q_push_o = accept & ~bad & frame_end;
  always_comb begin
    q_rec_o.type_byte = type_d;
    q_rec_o.length    = len_d;
    q_rec_o.seq       = (len_d >= 8'd1) ? seq_d : len_d;
    q_rec_o.command   = cmd_d;
    q_rec_o.status    = stat_d;
    priority if (len_d >= 8'd2) q_rec_o.frames = fc_d;
    else if (len_d == 8'd1)     q_rec_o.frames = len_d;
    else                        q_rec_o.frames = hdr4_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      type_q <= '0;
      len_q  <= '0;
      hdr4_q <= '0;
      cmd_q  <= '0;
      stat_q <= '0;
      seq_q  <= '0;
      fc_q   <= '0;
    end else begin
      cnt_q  <= cnt_d;
      type_q <= type_d;
      len_q  <= len_d;
      hdr4_q <= hdr4_d;
      cmd_q  <= cmd_d;
      stat_q <= stat_d;
      seq_q  <= seq_d;
      fc_q   <= fc_d;
    end
  end

endmodule

// File: sv/fbr_fifo.sv
// fbr_fifo: short queue of frame records between parser and classifier
// depends on fbr_pkg

module fbr_fifo import fbr_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_rec_t push_rec_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output frame_rec_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  frame_rec_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // pointer wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + (PtrW+1)'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - (PtrW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_rec_i;
  end

endmodule

// File: sv/fbr_back.sv
// fbr_back: frame classifier and output register
// depends on fbr_pkg

module fbr_back import fbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_empty_i,
  input  frame_rec_t  q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  frame_kind_o,
  output logic [7:0]  frame_type_byte_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  sequence_byte_o,
  output logic        send_ack_o,
  output logic [2:0]  ack_sequence_o,
  output logic        sms_sent_ok_o
);

  frame_kind_e kind_d, kind_q;
  logic        ok_d, ok_q, send_d, send_q, vld_q, vld_d, load;
  logic [7:0]  type_q, len_q, seq_q;

  // classification, ack match first
  always_comb begin
    ok_d   = 1'b0;
    send_d = 1'b1;
    priority if (q_head_i.type_byte == cfg_i.ack_byte) begin
      kind_d = KIND_ACK;
      send_d = 1'b0;
    end else if ((q_head_i.seq & SeqHiMask) != SeqHiOne || q_head_i.frames != OneFrame) begin
      kind_d = KIND_MULTI_DROP;
    end else if (q_head_i.type_byte == cfg_i.sms_type && q_head_i.command == SubSendStatus) begin
      kind_d = KIND_SMS_STATUS;
      ok_d   = (q_head_i.status == 8'h00);
    end else if (q_head_i.type_byte == cfg_i.id_type) begin
      kind_d = KIND_ID;
    end else if (q_head_i.type_byte == cfg_i.sms_type && q_head_i.command == SubIncoming) begin
      kind_d = KIND_SMS_INCOMING;
    end else if (q_head_i.type_byte == cfg_i.net_type) begin
      kind_d = KIND_NET_STATUS;
    end else begin
      kind_d = KIND_UNKNOWN;
    end
  end

  // output register refills while the current request is taken
  assign load    = ~q_empty_i & (~vld_q | out_ready_i);
  assign q_pop_o = load;

  always_comb begin
    vld_d = vld_q;
    priority if (load)             vld_d = 1'b1;
    else if (vld_q && out_ready_i) vld_d = 1'b0;
    else                           vld_d = vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      ok_q   <= ok_d;
      send_q <= send_d;
      type_q <= q_head_i.type_byte;
      len_q  <= q_head_i.length;
      seq_q  <= q_head_i.seq;
    end
  end

  assign out_valid_o       = vld_q;
  assign frame_kind_o      = kind_q;
  assign frame_type_byte_o = type_q;
  assign payload_length_o  = len_q;
  assign sequence_byte_o   = seq_q;
  assign send_ack_o        = send_q;
  assign ack_sequence_o    = send_q ? seq_q[2:0] : 3'd0;
  assign sms_sent_ok_o     = ok_q;

endmodule

// File: sv/fbr_checker.sv
// fbr_checker: port-level checks of the frame receiver, bound to the top level
// depends on fbr_pkg

module fbr_checker import fbr_pkg::*; #(
  parameter int unsigned MaxPayload = 128
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] frame_kind_i,
  input logic [7:0] payload_length_i,
  input logic [7:0] sequence_byte_i,
  input logic       send_ack_i,
  input logic [2:0] ack_sequence_i,
  input logic       sms_sent_ok_i
);

  // a stalled request stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("request dropped while stalled");

  // only acks go without an ack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (send_ack_i == (frame_kind_i != KIND_ACK)))
    else $error("send_ack does not match frame kind");

  // ack sequence follows the sequence byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (ack_sequence_i == (send_ack_i ? sequence_byte_i[2:0] : 3'd0)))
    else $error("ack sequence mismatch");

  // sent-ok only on sms status frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sms_sent_ok_i |-> frame_kind_i == KIND_SMS_STATUS)
    else $error("sms ok flag on wrong frame kind");

  // header length check held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> {1'b0, payload_length_i} <= 9'(MaxPayload))
    else $error("payload length above limit");

endmodule

bind fbus_frame_receiver_top fbr_checker #(.MaxPayload(MaxPayload)) u_fbr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .frame_kind_i     (frame_kind_o),
  .payload_length_i (payload_length_o),
  .sequence_byte_i  (sequence_byte_o),
  .send_ack_i       (send_ack_o),
  .ack_sequence_i   (ack_sequence_o),
  .sms_sent_ok_i    (sms_sent_ok_o)
);
